FILE: rtl/core/vbk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbk_pkg
// Shared types, widths and helpers of the Verlet ball kernel.
// ----------------------------------------------------------------------------
package vbk_pkg;

  localparam int POS_W   = 24;
  localparam int ACC_W   = 17;
  localparam int CTR_W   = 24;
  localparam int LIM_W   = 23;
  localparam int RAD_W   = 18;
  localparam int SUM_W   = 28;
  localparam int VEC_W   = 26;
  localparam int MAG_W   = 25;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int D2_W    = SQ_W + 1;
  localparam int LIM2_W  = 2 * LIM_W;
  localparam int M_W     = RAD_W + 1;
  localparam int M2_W    = 2 * M_W;
  localparam int RADP_W  = D2_W + 1;
  localparam int ROOT_W  = RADP_W / 2;
  localparam int SQR_W   = ROOT_W + 2;
  localparam int GAP_W   = ROOT_W + 1;
  localparam int Q_W     = 24;
  localparam int NUM_W   = MAG_W + LIM_W;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int QDEPTH  = 4;
  localparam int QCNT_W  = 3;
  localparam int QPTR_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_COLLIDE   = 1'b1;

  typedef enum logic [2:0] {
    REG_ACCEL_X  = 3'd0,
    REG_ACCEL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_RADIUS   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                    opcode;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_first_x;
    logic signed [POS_W-1:0] new_first_y;
    logic signed [POS_W-1:0] new_second_x;
    logic signed [POS_W-1:0] new_second_y;
    logic                    adjusted;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic [LIM_W-1:0]        limit;
    logic [RAD_W-1:0]        radius;
  } cfg_t;

  typedef struct packed {
    logic                    op;
    logic                    psat;
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
  } front_t;

  typedef struct packed {
    logic                    op;
    logic                    psat;
    logic                    adj;
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    neg_x;
    logic                    neg_y;
    logic [MAG_W-1:0]        mag_x;
    logic [MAG_W-1:0]        mag_y;
  } sq_tag_t;

  typedef struct packed {
    logic                    op;
    logic                    psat;
    logic                    adj;
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    neg_x;
    logic                    neg_y;
  } dv_tag_t;

  // clamp to the position range; msb of the result flags a clamp
  function automatic logic [POS_W:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return {1'b1, hi[POS_W-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[POS_W-1:0]};
    end
    return {1'b0, v[POS_W-1:0]};
  endfunction

endpackage

FILE: rtl/core/vbk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbk_front
// Accepts items, decodes the opcode and forms the Verlet prediction.
// ----------------------------------------------------------------------------
module vbk_front (
  input  logic                        clk,
  input  logic                        rst,
  input  vbk_pkg::cfg_t               cfg,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  vbk_pkg::item_t              item,
  input  logic [vbk_pkg::QCNT_W-1:0]  level,
  output logic                        push,
  output vbk_pkg::front_t             entry
);
  import vbk_pkg::*;

  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [POS_W:0]          sat_x;
  logic [POS_W:0]          sat_y;
  logic                    hold_valid;
  front_t                  hold;
  logic                    accept;

  assign item_ready = (level + QCNT_W'(hold_valid)) < QCNT_W'(QDEPTH);
  assign accept     = item_valid & item_ready;

  assign sum_x = (SUM_W'(item.first_x) <<< 1) - SUM_W'(item.second_x) + SUM_W'(cfg.accel_x);
  assign sum_y = (SUM_W'(item.first_y) <<< 1) - SUM_W'(item.second_y) + SUM_W'(cfg.accel_y);
  assign sat_x = sat_pos(sum_x);
  assign sat_y = sat_pos(sum_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept;
    end
    if (accept) begin
      hold.op   <= item.opcode;
      hold.fx   <= item.first_x;
      hold.fy   <= item.first_y;
      hold.sx   <= item.second_x;
      hold.sy   <= item.second_y;
      hold.px   <= sat_x[POS_W-1:0];
      hold.py   <= sat_y[POS_W-1:0];
      hold.psat <= (item.opcode == OP_INTEGRATE) & (sat_x[POS_W] | sat_y[POS_W]);
    end
  end

  assign push  = hold_valid;
  assign entry = hold;

endmodule

FILE: rtl/core/vbk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbk_queue
// Short queue between front and back.
// ----------------------------------------------------------------------------
module vbk_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  vbk_pkg::front_t             din,
  input  logic                        take,
  output logic                        head_valid,
  output vbk_pkg::front_t             head,
  output logic [vbk_pkg::QCNT_W-1:0]  level
);
  import vbk_pkg::*;

  front_t            mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign head_valid = count != '0;
  assign pop        = take & head_valid;
  assign head       = mem[rd_ptr];
  assign level      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/core/vbk_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbk_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vbk_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [vbk_pkg::D2_W-1:0]    radicand,
  input  vbk_pkg::sq_tag_t            in_tag,
  output logic                        out_valid,
  output logic [vbk_pkg::ROOT_W-1:0]  root,
  output vbk_pkg::sq_tag_t            out_tag
);
  import vbk_pkg::*;

  logic              st_valid [0:ROOT_W];
  logic [SQR_W-1:0]  st_rem   [0:ROOT_W];
  logic [ROOT_W-1:0] st_root  [0:ROOT_W];
  logic [RADP_W-1:0] st_rad   [0:ROOT_W];
  sq_tag_t           st_tag   [0:ROOT_W];

  assign st_valid[0] = in_valid;
  assign st_rem[0]   = '0;
  assign st_root[0]  = '0;
  assign st_rad[0]   = {1'b0, radicand};
  assign st_tag[0]   = in_tag;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [SQR_W-1:0] cur;
    logic [SQR_W-1:0] trial;
    logic             fit;

    assign cur   = {st_rem[s][SQR_W-3:0], st_rad[s][RADP_W-1 -: 2]};
    assign trial = {st_root[s], 2'b01};
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else if (en) begin
        st_valid[s+1] <= st_valid[s];
      end
      if (en) begin
        st_rem[s+1]  <= fit ? cur - trial : cur;
        st_root[s+1] <= {st_root[s][ROOT_W-2:0], fit};
        st_rad[s+1]  <= st_rad[s] << 2;
        st_tag[s+1]  <= st_tag[s];
      end
    end
  end

  assign out_valid = st_valid[ROOT_W];
  assign root      = st_root[ROOT_W];
  assign out_tag   = st_tag[ROOT_W];

endmodule

FILE: rtl/core/vbk_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbk_div
// Pipelined restoring divider, two numerators over one divisor.
// ----------------------------------------------------------------------------
module vbk_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [vbk_pkg::NUM_W-1:0]  num_x,
  input  logic [vbk_pkg::NUM_W-1:0]  num_y,
  input  logic [vbk_pkg::DEN_W-1:0]  den,
  input  vbk_pkg::dv_tag_t           in_tag,
  output logic                       out_valid,
  output logic [vbk_pkg::Q_W-1:0]    quo_x,
  output logic [vbk_pkg::Q_W-1:0]    quo_y,
  output vbk_pkg::dv_tag_t           out_tag
);
  import vbk_pkg::*;

  logic             st_valid [0:Q_W];
  logic [REM_W-1:0] st_rx    [0:Q_W];
  logic [REM_W-1:0] st_ry    [0:Q_W];
  logic [Q_W-1:0]   st_lx    [0:Q_W];
  logic [Q_W-1:0]   st_ly    [0:Q_W];
  logic [Q_W-1:0]   st_qx    [0:Q_W];
  logic [Q_W-1:0]   st_qy    [0:Q_W];
  logic [DEN_W-1:0] st_den   [0:Q_W];
  dv_tag_t          st_tag   [0:Q_W];

  assign st_valid[0] = in_valid;
  assign st_rx[0]    = REM_W'(num_x[NUM_W-1:Q_W]);
  assign st_ry[0]    = REM_W'(num_y[NUM_W-1:Q_W]);
  assign st_lx[0]    = num_x[Q_W-1:0];
  assign st_ly[0]    = num_y[Q_W-1:0];
  assign st_qx[0]    = '0;
  assign st_qy[0]    = '0;
  assign st_den[0]   = den;
  assign st_tag[0]   = in_tag;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [REM_W-1:0] tx;
    logic [REM_W-1:0] ty;
    logic             fx;
    logic             fy;

    assign tx = {st_rx[s][REM_W-2:0], st_lx[s][Q_W-1]};
    assign ty = {st_ry[s][REM_W-2:0], st_ly[s][Q_W-1]};
    assign fx = tx >= {1'b0, st_den[s]};
    assign fy = ty >= {1'b0, st_den[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else if (en) begin
        st_valid[s+1] <= st_valid[s];
      end
      if (en) begin
        st_rx[s+1]  <= fx ? tx - {1'b0, st_den[s]} : tx;
        st_ry[s+1]  <= fy ? ty - {1'b0, st_den[s]} : ty;
        st_lx[s+1]  <= st_lx[s] << 1;
        st_ly[s+1]  <= st_ly[s] << 1;
        st_qx[s+1]  <= {st_qx[s][Q_W-2:0], fx};
        st_qy[s+1]  <= {st_qy[s][Q_W-2:0], fy};
        st_den[s+1] <= st_den[s];
        st_tag[s+1] <= st_tag[s];
      end
    end
  end

  assign out_valid = st_valid[Q_W];
  assign quo_x     = st_qx[Q_W];
  assign quo_y     = st_qy[Q_W];
  assign out_tag   = st_tag[Q_W];

endmodule

FILE: rtl/core/vbk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbk_back
// Distance test, root, scaling division and final saturation.
// ----------------------------------------------------------------------------
module vbk_back (
  input  logic               clk,
  input  logic               rst,
  input  vbk_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  vbk_pkg::front_t    head,
  output logic               take,
  output logic               result_valid,
  input  logic               result_ready,
  output vbk_pkg::result_t   result
);
  import vbk_pkg::*;

  logic                    adv;
  logic signed [RAD_W:0]   rad_s;
  logic [M_W-1:0]          m;
  logic signed [VEC_W-1:0] vx;
  logic signed [VEC_W-1:0] vy;

  logic                    b0_valid;
  sq_tag_t                 b0;
  logic                    b1_valid;
  sq_tag_t                 b1;
  logic [SQ_W-1:0]         b1_sqx;
  logic [SQ_W-1:0]         b1_sqy;
  logic [LIM2_W-1:0]       b1_lim2;
  logic [M2_W-1:0]         b1_m2;
  logic [D2_W-1:0]         d2;
  logic                    b2_valid;
  sq_tag_t                 b2;
  sq_tag_t                 b2_next;
  logic [D2_W-1:0]         b2_d2;

  logic                    sq_valid;
  logic [ROOT_W-1:0]       sq_root;
  sq_tag_t                 sq_tag;
  logic signed [GAP_W-1:0] gap;
  logic [GAP_W-1:0]        gap_mag;
  logic                    kneg;
  logic                    b3_valid;
  sq_tag_t                 b3;
  sq_tag_t                 b3_next;
  logic [LIM_W-1:0]        b3_k;
  logic [DEN_W-1:0]        b3_den;

  logic                    b4_valid;
  dv_tag_t                 b4;
  logic [NUM_W-1:0]        b4_nx;
  logic [NUM_W-1:0]        b4_ny;
  logic [DEN_W-1:0]        b4_den;

  logic                    dv_valid;
  logic [Q_W-1:0]          qx;
  logic [Q_W-1:0]          qy;
  dv_tag_t                 dv;
  logic signed [Q_W:0]     sx_q;
  logic signed [Q_W:0]     sy_q;
  logic [POS_W:0]          r0;
  logic [POS_W:0]          r1;
  logic [POS_W:0]          r2;
  logic [POS_W:0]          r3;
  result_t                 res_next;

  assign adv   = ~result_valid | result_ready;
  assign take  = adv;
  assign rad_s = {1'b0, cfg.radius};
  assign m     = {cfg.radius, 1'b0};

  always_comb begin
    if (head.op == OP_INTEGRATE) begin
      vx = VEC_W'(cfg.center_x) - VEC_W'(head.px) - VEC_W'(rad_s);
      vy = VEC_W'(cfg.center_y) - VEC_W'(head.py) - VEC_W'(rad_s);
    end else begin
      vx = VEC_W'(head.fx) - VEC_W'(head.sx);
      vy = VEC_W'(head.fy) - VEC_W'(head.sy);
    end
  end

  assign d2 = {1'b0, b1_sqx} + {1'b0, b1_sqy};

  always_comb begin
    b2_next     = b1;
    b2_next.adj = (b1.op == OP_INTEGRATE) ? (d2 > D2_W'(b1_lim2))
                                          : ((d2 != '0) && (d2 < D2_W'(b1_m2)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else if (adv) begin
      b0_valid <= head_valid;
      b1_valid <= b0_valid;
      b2_valid <= b1_valid;
    end
    if (adv) begin
      b0.op    <= head.op;
      b0.psat  <= head.psat;
      b0.adj   <= 1'b0;
      b0.fx    <= head.fx;
      b0.fy    <= head.fy;
      b0.sx    <= head.sx;
      b0.sy    <= head.sy;
      b0.px    <= head.px;
      b0.py    <= head.py;
      b0.neg_x <= vx[VEC_W-1];
      b0.neg_y <= vy[VEC_W-1];
      b0.mag_x <= vx[VEC_W-1] ? MAG_W'(-vx) : MAG_W'(vx);
      b0.mag_y <= vy[VEC_W-1] ? MAG_W'(-vy) : MAG_W'(vy);

      b1      <= b0;
      b1_sqx  <= b0.mag_x * b0.mag_x;
      b1_sqy  <= b0.mag_y * b0.mag_y;
      b1_lim2 <= cfg.limit * cfg.limit;
      b1_m2   <= m * m;

      b2       <= b2_next;
      b2_d2    <= d2;
    end
  end

  vbk_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b2_valid),
    .radicand  (b2_d2),
    .in_tag    (b2),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  assign gap     = {1'b0, sq_root} - GAP_W'({1'b0, m});
  assign gap_mag = gap[GAP_W-1] ? unsigned'(-gap) : unsigned'(gap);
  assign kneg    = (sq_tag.op == OP_COLLIDE) & gap[GAP_W-1];

  always_comb begin
    b3_next       = sq_tag;
    b3_next.neg_x = sq_tag.neg_x ^ kneg;
    b3_next.neg_y = sq_tag.neg_y ^ kneg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
    end else if (adv) begin
      b3_valid <= sq_valid;
      b4_valid <= b3_valid;
    end
    if (adv) begin
      b3       <= b3_next;
      b3_k     <= (sq_tag.op == OP_INTEGRATE) ? cfg.limit : gap_mag[LIM_W-1:0];
      b3_den   <= (sq_tag.op == OP_INTEGRATE) ? DEN_W'(sq_root) : {sq_root, 1'b0};

      b4.op    <= b3.op;
      b4.psat  <= b3.psat;
      b4.adj   <= b3.adj;
      b4.fx    <= b3.fx;
      b4.fy    <= b3.fy;
      b4.sx    <= b3.sx;
      b4.sy    <= b3.sy;
      b4.px    <= b3.px;
      b4.py    <= b3.py;
      b4.neg_x <= b3.neg_x;
      b4.neg_y <= b3.neg_y;
      b4_nx    <= b3.mag_x * b3_k;
      b4_ny    <= b3.mag_y * b3_k;
      b4_den   <= b3_den;
    end
  end

  vbk_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b4_valid),
    .num_x     (b4_nx),
    .num_y     (b4_ny),
    .den       (b4_den),
    .in_tag    (b4),
    .out_valid (dv_valid),
    .quo_x     (qx),
    .quo_y     (qy),
    .out_tag   (dv)
  );

  assign sx_q = dv.neg_x ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
  assign sy_q = dv.neg_y ? -signed'({1'b0, qy}) : signed'({1'b0, qy});

  always_comb begin
    if (dv.op == OP_INTEGRATE) begin
      r0 = sat_pos(SUM_W'(cfg.center_x) - SUM_W'(sx_q) - SUM_W'(rad_s));
      r1 = sat_pos(SUM_W'(cfg.center_y) - SUM_W'(sy_q) - SUM_W'(rad_s));
      r2 = {1'b0, dv.fx};
      r3 = {1'b0, dv.fy};
      res_next.new_first_x  = dv.adj ? r0[POS_W-1:0] : dv.px;
      res_next.new_first_y  = dv.adj ? r1[POS_W-1:0] : dv.py;
      res_next.new_second_x = dv.fx;
      res_next.new_second_y = dv.fy;
      res_next.saturated    = dv.psat | (dv.adj & (r0[POS_W] | r1[POS_W]));
    end else begin
      r0 = sat_pos(SUM_W'(dv.fx) - SUM_W'(sx_q));
      r1 = sat_pos(SUM_W'(dv.fy) - SUM_W'(sy_q));
      r2 = sat_pos(SUM_W'(dv.sx) + SUM_W'(sx_q));
      r3 = sat_pos(SUM_W'(dv.sy) + SUM_W'(sy_q));
      res_next.new_first_x  = dv.adj ? r0[POS_W-1:0] : dv.fx;
      res_next.new_first_y  = dv.adj ? r1[POS_W-1:0] : dv.fy;
      res_next.new_second_x = dv.adj ? r2[POS_W-1:0] : dv.sx;
      res_next.new_second_y = dv.adj ? r3[POS_W-1:0] : dv.sy;
      res_next.saturated    = dv.adj & (r0[POS_W] | r1[POS_W] | r2[POS_W] | r3[POS_W]);
    end
    res_next.adjusted = dv.adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_valid;
    end
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

FILE: rtl/core/verlet_ball_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verlet_ball_kernel
// Verlet step with circular arena constraint, and pair collision push-apart.
//
//   channel   signals                                  beat
//   item      item_valid, item_ready, item             one ball or one pair
//   result    result_valid, result_ready, result       one result per item
//   config    psel, penable, pwrite, paddr, pwdata,    one register write
//             prdata, pready
//
// One item per cycle sustained while results are taken; the path from the item
// beat to the result runs mostly through the 26-stage root pipeline and the 24-stage divider.
// Reset clears the queue and all stage valids and loads register defaults.
// A stalled result freezes the back end; the front keeps taking beats until
// the four-entry queue fills.
// ----------------------------------------------------------------------------
module verlet_ball_kernel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  vbk_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output vbk_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vbk_pkg::ADDR_W-1:0]  paddr,
  input  logic [vbk_pkg::DATA_W-1:0]  pwdata,
  output logic [vbk_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import vbk_pkg::*;

  cfg_t              cfg;
  reg_idx_t          idx;
  logic              wr_en;
  logic              push;
  front_t            entry;
  logic              head_valid;
  front_t            head;
  logic              take;
  logic [QCNT_W-1:0] level;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_x  <= 17'sd0;
      cfg.accel_y  <= 17'sd11;
      cfg.center_x <= 24'sd1638400;
      cfg.center_y <= 24'sd1638400;
      cfg.limit    <= 23'd1613824;
      cfg.radius   <= 18'd24576;
    end else if (wr_en) begin
      unique case (idx)
        REG_ACCEL_X:  cfg.accel_x  <= pwdata[ACC_W-1:0];
        REG_ACCEL_Y:  cfg.accel_y  <= pwdata[ACC_W-1:0];
        REG_CENTER_X: cfg.center_x <= pwdata[CTR_W-1:0];
        REG_CENTER_Y: cfg.center_y <= pwdata[CTR_W-1:0];
        REG_LIMIT:    cfg.limit    <= pwdata[LIM_W-1:0];
        REG_RADIUS:   cfg.radius   <= pwdata[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACCEL_X:  prdata = {{(DATA_W-ACC_W){1'b0}}, cfg.accel_x};
      REG_ACCEL_Y:  prdata = {{(DATA_W-ACC_W){1'b0}}, cfg.accel_y};
      REG_CENTER_X: prdata = {{(DATA_W-CTR_W){1'b0}}, cfg.center_x};
      REG_CENTER_Y: prdata = {{(DATA_W-CTR_W){1'b0}}, cfg.center_y};
      REG_LIMIT:    prdata = {{(DATA_W-LIM_W){1'b0}}, cfg.limit};
      REG_RADIUS:   prdata = {{(DATA_W-RAD_W){1'b0}}, cfg.radius};
      default:      prdata = '0;
    endcase
  end

  vbk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .level      (level),
    .push       (push),
    .entry      (entry)
  );

  vbk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din        (entry),
    .take       (take),
    .head_valid (head_valid),
    .head       (head),
    .level      (level)
  );

  vbk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .take         (take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Verlet ball kernel. Integrate and collide
// items are sent over a valid/ready channel, and each one is predicted in
// 64-bit integer arithmetic against the registers the bench has written.
// Results are compared field by field, in order. Register settings are
// swept between phases while the kernel is idle. Both sides stall at
// random, and one phase holds off results long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import vbk_pkg::*;

  localparam int  DRAIN_CYCLES = 70;
  localparam int  IDLE_LIMIT   = 3000;
  localparam longint POS_MAX   = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN   = -POS_MAX - 1;

  logic                clk = 1'b0;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  item_t               item;
  logic                result_valid;
  logic                result_ready;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // register copies, sign-extended
  longint acc_x = 0, acc_y = 11, ctr_x = 1638400, ctr_y = 1638400;
  longint arena_lim = 1613824, ball_rad = 24576;

  result_t pending_results[$];
  int      errors = 0;
  int      beats_in = 0, beats_out = 0, adjusted_seen = 0, saturated_seen = 0;
  int      hold_cycles = 0;
  int      stall_left = 0;
  bit      quiet = 1'b0;
  int      idle_count = 0;

  verlet_ball_kernel u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic longint clamp_pos(longint v, inout bit flag);
    if (v > POS_MAX) begin
      flag = 1'b1;
      return POS_MAX;
    end
    if (v < POS_MIN) begin
      flag = 1'b1;
      return POS_MIN;
    end
    return v;
  endfunction

  function automatic longint floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic result_t kernel_result(item_t it);
    result_t r;
    longint fx, fy, sx, sy, o0, o1, o2, o3, vx, vy, d2, d, m, gap, shx, shy;
    bit sat;
    bit adj;
    fx = it.first_x;
    fy = it.first_y;
    sx = it.second_x;
    sy = it.second_y;
    sat = 1'b0;
    adj = 1'b0;
    if (it.opcode == OP_INTEGRATE) begin
      o0 = clamp_pos(2 * fx - sx + acc_x, sat);
      o1 = clamp_pos(2 * fy - sy + acc_y, sat);
      vx = ctr_x - (o0 + ball_rad);
      vy = ctr_y - (o1 + ball_rad);
      d2 = vx * vx + vy * vy;
      if (d2 > arena_lim * arena_lim) begin
        d = floor_root(d2);
        adj = 1'b1;
        o0 = clamp_pos(ctr_x - (vx * arena_lim) / d - ball_rad, sat);
        o1 = clamp_pos(ctr_y - (vy * arena_lim) / d - ball_rad, sat);
      end
      o2 = fx;
      o3 = fy;
    end else begin
      vx = fx - sx;
      vy = fy - sy;
      d2 = vx * vx + vy * vy;
      m = 2 * ball_rad;
      o0 = fx; o1 = fy; o2 = sx; o3 = sy;
      if (d2 != 0 && d2 < m * m) begin
        d = floor_root(d2);
        gap = d - m;
        shx = (vx * gap) / (2 * d);
        shy = (vy * gap) / (2 * d);
        adj = 1'b1;
        o0 = clamp_pos(fx - shx, sat);
        o1 = clamp_pos(fy - shy, sat);
        o2 = clamp_pos(sx + shx, sat);
        o3 = clamp_pos(sy + shy, sat);
      end
    end
    r.new_first_x  = o0[POS_W-1:0];
    r.new_first_y  = o1[POS_W-1:0];
    r.new_second_x = o2[POS_W-1:0];
    r.new_second_y = o3[POS_W-1:0];
    r.adjusted     = adj;
    r.saturated    = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (result.new_first_x != want.new_first_x)
          report_mismatch("new_first_x", result.new_first_x, want.new_first_x);
        if (result.new_first_y != want.new_first_y)
          report_mismatch("new_first_y", result.new_first_y, want.new_first_y);
        if (result.new_second_x != want.new_second_x)
          report_mismatch("new_second_x", result.new_second_x, want.new_second_x);
        if (result.new_second_y != want.new_second_y)
          report_mismatch("new_second_y", result.new_second_y, want.new_second_y);
        if (result.adjusted != want.adjusted)
          report_mismatch("adjusted", result.adjusted, want.adjusted);
        if (result.saturated != want.saturated)
          report_mismatch("saturated", result.saturated, want.saturated);
        adjusted_seen  += want.adjusted;
        saturated_seen += want.saturated;
      end
    end
  end

  // result side stalls
  always @(posedge clk) begin
    int r;
    if (rst) begin
      result_ready <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (!quiet && r < 12) begin
        stall_left = $urandom_range(0, 2);
        result_ready <= 1'b0;
      end else if (!quiet && r < 14) begin
        stall_left = $urandom_range(15, 50);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("[verlet_ball_kernel] ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_item(item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    pending_results.insert(pending_results.size(), kernel_result(it));
    beats_in++;
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, longint v);
    int w;
    longint raw;
    case (idx)
      REG_ACCEL_X, REG_ACCEL_Y:   w = ACC_W;
      REG_CENTER_X, REG_CENTER_Y: w = CTR_W;
      REG_LIMIT:                  w = LIM_W;
      default:                    w = RAD_W;
    endcase
    raw = v & ((64'sd1 <<< w) - 1);
    case (idx)
      REG_ACCEL_X:  acc_x = (raw ^ (64'sd1 <<< (w - 1))) - (64'sd1 <<< (w - 1));
      REG_ACCEL_Y:  acc_y = (raw ^ (64'sd1 <<< (w - 1))) - (64'sd1 <<< (w - 1));
      REG_CENTER_X: ctr_x = (raw ^ (64'sd1 <<< (w - 1))) - (64'sd1 <<< (w - 1));
      REG_CENTER_Y: ctr_y = (raw ^ (64'sd1 <<< (w - 1))) - (64'sd1 <<< (w - 1));
      REG_LIMIT:    arena_lim = raw;
      default:      ball_rad = raw;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(raw);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all(longint ax, longint ay, longint cx, longint cy,
                           longint lim, longint rad);
    write_reg(REG_ACCEL_X, ax);
    write_reg(REG_ACCEL_Y, ay);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_RADIUS, rad);
  endtask

  function automatic logic signed [POS_W-1:0] near_pos(longint v, longint span);
    longint p;
    p = v + longint'($urandom_range(0, 2 * span)) - span;
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    return p[POS_W-1:0];
  endfunction

  function automatic item_t make_item(logic op, longint fx, longint fy,
                                      longint sx, longint sy);
    item_t it;
    it.opcode   = op;
    it.first_x  = fx[POS_W-1:0];
    it.first_y  = fy[POS_W-1:0];
    it.second_x = sx[POS_W-1:0];
    it.second_y = sy[POS_W-1:0];
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    longint span;
    r = $urandom_range(0, 99);
    it.opcode = 1'($urandom_range(0, 1));
    if (r < 20) begin
      it.first_x  = POS_W'($urandom());
      it.first_y  = POS_W'($urandom());
      it.second_x = POS_W'($urandom());
      it.second_y = POS_W'($urandom());
    end else if (it.opcode == OP_INTEGRATE) begin
      span = arena_lim + arena_lim / 4 + 16;
      it.first_x  = near_pos(ctr_x - ball_rad, span);
      it.first_y  = near_pos(ctr_y - ball_rad, span);
      it.second_x = near_pos(it.first_x, 2000);
      it.second_y = near_pos(it.first_y, 2000);
    end else begin
      span = 2 * ball_rad + 8;
      it.first_x  = near_pos(ctr_x + longint'($urandom_range(0, 4000000)) - 2000000, 16);
      it.first_y  = near_pos(ctr_y + longint'($urandom_range(0, 4000000)) - 2000000, 16);
      it.second_x = near_pos(it.first_x, (r < 25) ? 0 : span);
      it.second_y = near_pos(it.first_y, (r < 25) ? 0 : span);
    end
    return it;
  endfunction

  task automatic send_random(int n);
    repeat (n) begin
      send_item(random_item());
      pause_sender(pick_gap());
    end
  endtask

  task automatic test_integrate_directed();
    longint c;
    c = ctr_x - ball_rad;
    send_item(make_item(OP_INTEGRATE, c, c, c, c));
    send_item(make_item(OP_INTEGRATE, 0, 0, 0, 0));
    send_item(make_item(OP_INTEGRATE, POS_MAX, POS_MAX, POS_MIN, POS_MIN));
    send_item(make_item(OP_INTEGRATE, POS_MIN, POS_MIN, POS_MAX, POS_MAX));
    send_item(make_item(OP_INTEGRATE, POS_MAX, POS_MIN, POS_MAX, POS_MIN));
    send_item(make_item(OP_INTEGRATE, c + arena_lim, c, c + arena_lim, c));
    send_item(make_item(OP_INTEGRATE, c + arena_lim + 100, c, c + arena_lim, c));
    send_item(make_item(OP_INTEGRATE, c, c - arena_lim - 5, c, c - arena_lim));
    drain();
  endtask

  task automatic test_collide_directed();
    longint m;
    m = 2 * ball_rad;
    send_item(make_item(OP_COLLIDE, 1000, 1000, 1000, 1000));
    send_item(make_item(OP_COLLIDE, 0, 0, m, 0));
    send_item(make_item(OP_COLLIDE, 0, 0, m - 1, 0));
    send_item(make_item(OP_COLLIDE, 0, 0, m + 1, 0));
    send_item(make_item(OP_COLLIDE, 0, 0, 1, 1));
    send_item(make_item(OP_COLLIDE, 500, 700, 500 - m / 3, 700 + m / 4));
    send_item(make_item(OP_COLLIDE, POS_MAX, POS_MAX, POS_MAX - 10, POS_MAX - 10));
    send_item(make_item(OP_COLLIDE, POS_MIN, POS_MIN, POS_MIN + 10, POS_MIN + 3));
    send_item(make_item(OP_COLLIDE, POS_MAX, POS_MIN, POS_MIN, POS_MAX));
    send_item(make_item(OP_COLLIDE, -5, -5, 5, 5));
    drain();
  endtask

  task automatic test_default_random();
    send_random(200);
    drain();
  endtask

  task automatic test_register_sweep();
    write_all(65535, -65536, 8388607, -8388608, 8388607, 262143);
    send_random(120);
    drain();
    write_all(-65536, 65535, -8388608, 8388607, 0, 0);
    send_random(120);
    drain();
    write_all(-3, 20, 0, 0, 40000, 100);
    test_collide_directed();
    test_integrate_directed();
    send_random(150);
    drain();
    repeat (4) begin
      write_all(longint'($urandom_range(0, 400)) - 200,
                longint'($urandom_range(0, 400)) - 200,
                longint'($urandom_range(0, 8000000)) - 4000000,
                longint'($urandom_range(0, 8000000)) - 4000000,
                $urandom_range(0, 3000000), $urandom_range(0, 60000));
      send_random(150);
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    quiet = 1'b1;
    repeat (90) send_item(random_item());
    drain();
    quiet = 1'b0;
    send_random(40);
    drain();
  endtask

  initial begin
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_integrate_directed();
    test_collide_directed();
    test_default_random();
    test_backpressure();
    test_register_sweep();
    write_all(0, 11, 1638400, 1638400, 1613824, 24576);
    quiet = 1'b1;
    send_random(100);
    drain();
    $display("ran %0d items, %0d results (%0d adjusted, %0d clamped)",
             beats_in, beats_out, adjusted_seen, saturated_seen);
    $display("covered default, extreme and random registers, plus a held-off output");
    if (errors == 0) begin
      $display("[verlet_ball_kernel] OK");
    end else begin
      $display("[verlet_ball_kernel] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/vbk_pkg.sv
rtl/core/vbk_front.sv
rtl/core/vbk_queue.sv
rtl/core/vbk_sqrt.sv
rtl/core/vbk_div.sv
rtl/core/vbk_back.sv
rtl/core/verlet_ball_kernel.sv
test/tb_top.sv
